// ===== rtl/rfvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfvc_pkg
// Shared types, codes and default sizes for the random forest vote classifier.
// ----------------------------------------------------------------------------
package rfvc_pkg;

  localparam int TREES_DEF      = 64;
  localparam int NODES_DEF      = 512;
  localparam int FEATURES_DEF   = 6;
  localparam int WALK_LIMIT_DEF = 16;

  localparam int CLASSES = 3;
  localparam int VOTE_W  = 7;

  // request codes
  localparam logic [1:0] REQ_LOAD_NODE = 2'd0;
  localparam logic [1:0] REQ_LOAD_FEAT = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_DROP  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         tree_index;
    logic [8:0]         node_pos;
    logic               leaf_flag;
    logic [2:0]         feature_index;
    logic signed [31:0] value;
    logic [8:0]         left_index;
    logic [8:0]         right_index;
    logic [2:0]         leaf_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        predicted_class;
    logic [VOTE_W-1:0] winning_votes;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic               leaf;
    logic [2:0]         feature;
    logic signed [31:0] threshold;
    logic [8:0]         left;
    logic [8:0]         right;
    logic [2:0]         cls;
  } node_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_node;
    logic load_feat;
    logic cls_start;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic tree_end;
    logic last_tree;
  } sts_t;

endpackage

// ===== rtl/random_forest_vote_classifier.sv =====
// ----------------------------------------------------------------------------
// random_forest_vote_classifier
// Three-class random forest with majority vote over the trees in use.
// ----------------------------------------------------------------------------
// Loads leave busy low; a new item may follow at once.
// A classify walks the trees in use, visiting at most WALK_LIMIT + 1 nodes per tree,
// then strobes the result; with no tree in use it strobes without a walk.
// Busy drops in the strobe cycle. One node store read per cycle, one node per cycle.
// The result strobe lasts one cycle; the receiver cannot stall it. Reset (rst_n low,
// synchronous) clears sequencer, tree count and strobe; the stores are not cleared.
module random_forest_vote_classifier #(
  parameter int TREES      = rfvc_pkg::TREES_DEF,
  parameter int NODES      = rfvc_pkg::NODES_DEF,
  parameter int FEATURES   = rfvc_pkg::FEATURES_DEF,
  parameter int WALK_LIMIT = rfvc_pkg::WALK_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rfvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output rfvc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import rfvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rfvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  rfvc_datapath #(
    .TREES      (TREES),
    .NODES      (NODES),
    .FEATURES   (FEATURES),
    .WALK_LIMIT (WALK_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a classify transaction in progress");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == REQ_CLASSIFY) |=> busy)
    else $error("classify transaction accepted but block not busy");

  a_empty_no_votes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_EMPTY) |->
      (out_data.winning_votes == '0 && out_data.predicted_class == 2'd0))
    else $error("empty forest reported votes");

endmodule

// ===== rtl/rfvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfvc_ctrl
// Sequencer: decodes requests and steps the datapath through the tree walks.
// ----------------------------------------------------------------------------
module rfvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  rfvc_pkg::sts_t    sts,
  output rfvc_pkg::cmd_t    cmd,
  output logic              busy
);
  import rfvc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && req_type == REQ_CLASSIFY) begin
          state_nxt = sts.empty ? S_FINISH : S_WALK;
        end
      end
      S_WALK: begin
        if (sts.tree_end && sts.last_tree) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (req_type)
            REQ_LOAD_NODE: cmd.load_node = 1'b1;
            REQ_LOAD_FEAT: cmd.load_feat = 1'b1;
            REQ_CLASSIFY:  cmd.cls_start = 1'b1;
            REQ_UNUSED:    cmd           = '0;
            default:       cmd           = '0;
          endcase
        end
      end
      S_WALK:   cmd.walk   = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      default:  busy       = 1'b1;
    endcase
  end

endmodule

// ===== rtl/rfvc_datapath.sv =====
// ----------------------------------------------------------------------------
// rfvc_datapath
// Node and feature stores, node evaluation, vote counters and result register.
// ----------------------------------------------------------------------------
module rfvc_datapath #(
  parameter int TREES      = rfvc_pkg::TREES_DEF,
  parameter int NODES      = rfvc_pkg::NODES_DEF,
  parameter int FEATURES   = rfvc_pkg::FEATURES_DEF,
  parameter int WALK_LIMIT = rfvc_pkg::WALK_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfvc_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  rfvc_pkg::cmd_t      cmd,
  output rfvc_pkg::sts_t      sts,
  output logic                out_valid,
  output rfvc_pkg::out_item_t out_data
);
  import rfvc_pkg::*;

  localparam int TREE_W  = (TREES > 1) ? $clog2(TREES) : 1;
  localparam int NODE_W  = $clog2(NODES);
  localparam int TCNT_W  = $clog2(TREES + 1);
  localparam int MOVE_W  = $clog2(WALK_LIMIT + 1);
  localparam int FEAT_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int FDEPTH  = 1 << FEAT_W;
  localparam int ADDR_W  = TREE_W + NODE_W;
  localparam int DEPTH   = 1 << ADDR_W;

  // stores
  node_t              node_mem [DEPTH];
  node_t              rd_r;
  logic signed [31:0] feat_r [FDEPTH];

  logic [6:0]         n_trees_r;
  logic [TCNT_W-1:0]  trees_r;
  logic [TCNT_W-1:0]  tree_r, tree_nxt;
  logic [MOVE_W-1:0]  moves_r;
  logic [VOTE_W-1:0]  cnt_r [CLASSES];
  logic               drop_r;
  logic               empty_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [7:0]         tree_ext;
  logic [10:0]        node_ext;
  logic               node_ok;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [7:0]         ntr_ext, ntr_eff;

  logic               at_limit;
  logic signed [31:0] fval;
  logic               go_left;
  logic [10:0]        child;
  logic               child_oob;
  logic               tree_end;
  logic               vote;
  logic               drop;

  logic [1:0]         best;
  logic [VOTE_W-1:0]  best_votes;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_trees_r <= '0;
    end else if (cfg_we) begin
      n_trees_r <= cfg_wdata;
    end
  end

  // node load
  assign tree_ext = 8'(in_data.tree_index);
  assign node_ext = 11'(in_data.node_pos);
  assign node_ok  = (tree_ext < 8'(TREES)) && (node_ext < 11'(NODES));
  assign waddr    = {tree_ext[TREE_W-1:0], node_ext[NODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load_node && node_ok) begin
      node_mem[waddr] <= '{leaf:      in_data.leaf_flag,
                           feature:   in_data.feature_index,
                           threshold: in_data.value,
                           left:      in_data.left_index,
                           right:     in_data.right_index,
                           cls:       in_data.leaf_class};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= node_mem[raddr];
  end

  // feature load
  always_ff @(posedge clk) begin
    if (cmd.load_feat && (4'(in_data.feature_index) < 4'(FEATURES))) begin
      feat_r[in_data.feature_index[FEAT_W-1:0]] <= in_data.value;
    end
  end

  // node evaluation, one node per cycle
  always_comb begin
    at_limit  = moves_r >= MOVE_W'(WALK_LIMIT);
    fval      = (4'(rd_r.feature) < 4'(FEATURES)) ? feat_r[rd_r.feature[FEAT_W-1:0]] : '0;
    go_left   = fval <= rd_r.threshold;
    child     = go_left ? 11'(rd_r.left) : 11'(rd_r.right);
    child_oob = child >= 11'(NODES);
    tree_end  = rd_r.leaf || at_limit || child_oob;
    vote      = rd_r.leaf && (rd_r.cls < 3'(CLASSES));
    drop      = !rd_r.leaf && (at_limit || child_oob);
    tree_nxt  = tree_r + 1'b1;
  end

  // next read: the next child, or node 0 of the next tree; node 0 of tree 0 when idle
  always_comb begin
    raddr = '0;
    if (cmd.walk) begin
      if (tree_end) begin
        raddr = {tree_nxt[TREE_W-1:0], NODE_W'(0)};
      end else begin
        raddr = {tree_r[TREE_W-1:0], child[NODE_W-1:0]};
      end
    end
  end

  assign ntr_ext = 8'(n_trees_r);
  assign ntr_eff = (ntr_ext > 8'(TREES)) ? 8'(TREES) : ntr_ext;

  always_ff @(posedge clk) begin
    if (cmd.cls_start) begin
      trees_r  <= ntr_eff[TCNT_W-1:0];
      empty_r  <= (n_trees_r == '0);
      tree_r   <= '0;
      moves_r  <= '0;
      drop_r   <= 1'b0;
      for (int i = 0; i < CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.walk) begin
      if (tree_end) begin
        tree_r  <= tree_nxt;
        moves_r <= '0;
      end else begin
        moves_r <= moves_r + 1'b1;
      end
      if (drop) begin
        drop_r <= 1'b1;
      end
      if (vote) begin
        cnt_r[rd_r.cls[1:0]] <= cnt_r[rd_r.cls[1:0]] + 1'b1;
      end
    end
  end

  assign sts.empty     = (n_trees_r == '0);
  assign sts.tree_end  = tree_end;
  assign sts.last_tree = (tree_nxt == trees_r);

  // tally: strict compare keeps the lowest class on a tie
  always_comb begin
    best       = 2'd0;
    best_votes = cnt_r[0];
    if (cnt_r[1] > best_votes) begin
      best       = 2'd1;
      best_votes = cnt_r[1];
    end
    if (cnt_r[2] > best_votes) begin
      best       = 2'd2;
      best_votes = cnt_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.predicted_class <= best;
      out_data_r.winning_votes   <= best_votes;
      out_data_r.status          <= empty_r ? STAT_EMPTY : (drop_r ? STAT_DROP : STAT_OK);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/random_forest_vote_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// random_forest_vote_classifier_tb
// Drives tree node loads, feature loads and classify requests into the forest
// and checks each vote result against a predictor that walks its own copy of
// the trees. Directed tests cover the vote rules and corner cases, then
// random tree builds and classifies run under several sender idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module random_forest_vote_classifier_tb;
  import rfvc_pkg::*;

  localparam int TREES      = TREES_DEF;
  localparam int NODES      = NODES_DEF;
  localparam int FEATURES   = FEATURES_DEF;
  localparam int WALK_LIMIT = WALK_LIMIT_DEF;
  localparam int RUN_LIMIT  = 5_000_000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_data   = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  // predictor state
  node_t              forest_mem   [TREES*NODES];
  bit                 node_loaded  [TREES*NODES];
  logic [8:0]         loaded_list  [TREES][NODES];
  int                 loaded_count [TREES];
  logic signed [31:0] feature_mem  [FEATURES] = '{default: '0};
  logic [6:0]         tree_count = '0;
  out_item_t          vote_q [$];
  out_item_t          want_vote;

  int mismatches       = 0;
  int useful_items     = 0;
  int sender_idle_pct  = 0;
  int cycle_count      = 0;

  random_forest_vote_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
  endtask

  // ---- predictor --------------------------------------------------------

  // leaf class, or -1 when the walk is dropped
  function automatic int walk_tree(int t);
    int                 n;
    int                 moves;
    node_t              nd;
    logic signed [31:0] f;
    logic signed [31:0] thr;
    n = 0;
    moves = 0;
    while (1) begin
      nd = forest_mem[t*NODES + n];
      if (nd.leaf)
        return int'(nd.cls);
      if (moves >= WALK_LIMIT)
        return -1;
      thr = nd.threshold;
      f = (int'(nd.feature) < FEATURES) ? feature_mem[int'(nd.feature)] : '0;
      n = (f <= thr) ? int'(nd.left) : int'(nd.right);
      if (n >= NODES)
        return -1;
      moves++;
    end
  endfunction

  function automatic out_item_t predict_vote();
    int        votes [CLASSES];
    int        trees;
    int        cls;
    int        best;
    out_item_t res;
    res = '0;
    trees = (int'(tree_count) > TREES) ? TREES : int'(tree_count);
    if (trees == 0) begin
      res.status = STAT_EMPTY;
      return res;
    end
    foreach (votes[i]) votes[i] = 0;
    for (int t = 0; t < trees; t++) begin
      cls = walk_tree(t);
      if (cls < 0)
        res.status = STAT_DROP;
      else if (cls < CLASSES)
        votes[cls]++;
    end
    best = 0;
    for (int i = 1; i < CLASSES; i++)
      if (votes[i] > votes[best]) best = i;
    res.predicted_class = 2'(best);
    res.winning_votes = VOTE_W'(votes[best]);
    return res;
  endfunction

  function automatic void absorb_item(in_item_t it);
    int    slot;
    node_t nd;
    case (it.req_type)
      REQ_LOAD_NODE: begin
        slot = int'(it.tree_index) * NODES + int'(it.node_pos);
        nd.leaf = it.leaf_flag;
        nd.feature = it.feature_index;
        nd.threshold = it.value;
        nd.left = it.left_index;
        nd.right = it.right_index;
        nd.cls = it.leaf_class;
        forest_mem[slot] = nd;
        if (!node_loaded[slot]) begin
          node_loaded[slot] = 1'b1;
          loaded_list[it.tree_index][loaded_count[it.tree_index]] = it.node_pos;
          loaded_count[it.tree_index]++;
        end
        useful_items++;
      end
      REQ_LOAD_FEAT: begin
        if (int'(it.feature_index) < FEATURES) begin
          feature_mem[int'(it.feature_index)] = it.value;
          useful_items++;
        end
      end
      REQ_CLASSIFY: begin
        vote_q.push_back(predict_vote());
        useful_items++;
      end
      default: ;
    endcase
  endfunction

  // ---- result checker ---------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (vote_q.size() == 0) begin
        report_mismatch("unexpected result, class", int'(out_data.predicted_class), -1);
      end else begin
        want_vote = vote_q.pop_front();
        if (out_data.predicted_class !== want_vote.predicted_class)
          report_mismatch("predicted_class", int'(out_data.predicted_class),
                          int'(want_vote.predicted_class));
        if (out_data.winning_votes !== want_vote.winning_votes)
          report_mismatch("winning_votes", int'(out_data.winning_votes),
                          int'(want_vote.winning_votes));
        if (out_data.status !== want_vote.status)
          report_mismatch("status", int'(out_data.status), int'(want_vote.status));
      end
    end
  end

  // ---- item builders ----------------------------------------------------

  function automatic in_item_t random_item(logic [1:0] req);
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.req_type = req;
    return it;
  endfunction

  function automatic in_item_t leaf_item(int t, logic [8:0] n, logic [2:0] cls);
    in_item_t it;
    it = random_item(REQ_LOAD_NODE);
    it.tree_index = 6'(t);
    it.node_pos = n;
    it.leaf_flag = 1'b1;
    it.leaf_class = cls;
    return it;
  endfunction

  function automatic in_item_t split_item(int t, logic [8:0] n, logic [2:0] feat,
                                          logic signed [31:0] thr,
                                          logic [8:0] l, logic [8:0] r);
    in_item_t it;
    it = random_item(REQ_LOAD_NODE);
    it.tree_index = 6'(t);
    it.node_pos = n;
    it.leaf_flag = 1'b0;
    it.feature_index = feat;
    it.value = thr;
    it.left_index = l;
    it.right_index = r;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int near_zero;
    near_zero = int'($urandom_range(0, 4095)) - 2048;
    case ($urandom_range(0, 7))
      0, 1, 2: return near_zero;
      3:       return $urandom;
      4:       return 32'sh7FFF_FFFF;
      5:       return 32'sh8000_0000;
      default: return feature_mem[$urandom_range(0, FEATURES-1)];
    endcase
  endfunction

  function automatic logic [2:0] pick_class();
    return ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom);
  endfunction

  function automatic logic [2:0] pick_feature();
    return ($urandom_range(0, 6) != 0) ? 3'($urandom_range(0, FEATURES-1)) : 3'($urandom);
  endfunction

  function automatic logic [8:0] fresh_index();
    return 9'($urandom_range(1, NODES-1));
  endfunction

  function automatic logic [8:0] known_index(int t);
    return loaded_list[t][$urandom_range(0, loaded_count[t]-1)];
  endfunction

  function automatic int pick_tree();
    int in_use;
    in_use = (int'(tree_count) > TREES) ? TREES : int'(tree_count);
    if (in_use > 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, in_use-1);
    return $urandom_range(0, TREES-1);
  endfunction

  function automatic logic [6:0] pick_tree_count();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'($urandom_range(65, 126));
      5, 6:    return 7'($urandom_range(1, 8));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // ---- driving ----------------------------------------------------------

  // start is left high after acceptance unless a gap follows; callers that
  // stop sending go through drain, which lowers it
  task automatic send_item(input in_item_t it);
    int gap;
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_item(it);
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (vote_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tree_count(input logic [6:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    tree_count = n;
  endtask

  task automatic classify();
    send_item(random_item(REQ_CLASSIFY));
  endtask

  task automatic load_feature(input logic [2:0] fi, input logic signed [31:0] v);
    in_item_t it;
    it = random_item(REQ_LOAD_FEAT);
    it.feature_index = fi;
    it.value = v;
    send_item(it);
  endtask

  // random binary tree, built leaves first so every child exists before use;
  // the last split lands on node 0
  task automatic grow_tree(input int t);
    logic [8:0] pool [8];
    int         pool_n;
    int         leaves;
    int         a;
    logic [8:0] ca;
    logic [8:0] cb;
    logic [8:0] idx;
    leaves = $urandom_range(1, 6);
    for (int i = 0; i < leaves; i++) begin
      idx = (leaves == 1) ? 9'd0 : fresh_index();
      send_item(leaf_item(t, idx, pick_class()));
      pool[i] = idx;
    end
    pool_n = leaves;
    while (pool_n > 1) begin
      a = $urandom_range(0, pool_n-1);
      ca = pool[a];
      pool[a] = pool[pool_n-1];
      pool_n--;
      a = $urandom_range(0, pool_n-1);
      cb = pool[a];
      pool[a] = pool[pool_n-1];
      pool_n--;
      idx = (pool_n == 0) ? 9'd0 : fresh_index();
      send_item(split_item(t, idx, pick_feature(), pick_value(), ca, cb));
      pool[pool_n] = idx;
      pool_n++;
    end
  endtask

  // straight chain whose depth straddles the walk limit
  task automatic grow_chain(input int t);
    int         len;
    logic [8:0] below;
    logic [8:0] idx;
    len = $urandom_range(WALK_LIMIT-1, WALK_LIMIT+2);
    below = fresh_index();
    send_item(leaf_item(t, below, pick_class()));
    for (int i = 1; i < len; i++) begin
      idx = (i == len-1) ? 9'd0 : fresh_index();
      send_item(split_item(t, idx, pick_feature(), pick_value(), below, below));
      below = idx;
    end
  endtask

  // overwrite one node; children may point back up the tree and form loops
  task automatic poke_node(input int t);
    logic [8:0] idx;
    idx = $urandom_range(0, 1) ? known_index(t) : fresh_index();
    if ($urandom_range(0, 1))
      send_item(leaf_item(t, idx, pick_class()));
    else
      send_item(split_item(t, idx, pick_feature(), pick_value(),
                           known_index(t), known_index(t)));
  endtask

  // ---- tests ------------------------------------------------------------

  // the stores are not cleared by reset: give every tree a root before any
  // classify can walk it
  task automatic init_stores();
    for (int f = 0; f < FEATURES; f++)
      load_feature(3'(f), pick_value());
    for (int t = 0; t < TREES; t++)
      send_item(leaf_item(t, 9'd0, 3'($urandom)));
  endtask

  task automatic test_empty_forest();
    classify();
    set_tree_count(7'd0);
    classify();
  endtask

  task automatic test_vote_rules();
    set_tree_count(7'd3);
    send_item(leaf_item(0, 9'd1, 3'd2));
    send_item(leaf_item(0, 9'd2, 3'd1));
    // feature equal to threshold goes left
    send_item(split_item(0, 9'd0, 3'd0, feature_mem[0], 9'd1, 9'd2));
    // class outside 0..2 casts no vote
    send_item(leaf_item(1, 9'd0, 3'd5));
    send_item(leaf_item(2, 9'd1, 3'd2));
    send_item(leaf_item(2, 9'd2, 3'd0));
    // feature slot beyond the store reads as zero, so right; tie goes to class 0
    send_item(split_item(2, 9'd0, 3'd6, 32'shFFFF_FFFF, 9'd1, 9'd2));
    classify();
  endtask

  task automatic test_walk_limit();
    set_tree_count(7'd1);
    send_item(split_item(0, 9'd0, 3'd0, pick_value(), 9'd0, 9'd0));
    classify();
  endtask

  task automatic test_value_extremes();
    set_tree_count(7'd3);
    load_feature(3'd0, 32'sh7FFF_FFFF);
    load_feature(3'd1, 32'sh8000_0000);
    send_item(split_item(0, 9'd0, 3'd0, 32'sh7FFF_FFFF, 9'd1, 9'd2));
    send_item(split_item(2, 9'd0, 3'd1, 32'sh8000_0000, 9'd1, 9'd2));
    classify();
    load_feature(3'd0, 32'sh8000_0000);
    load_feature(3'd1, 32'sh7FFF_FFFF);
    classify();
  endtask

  task automatic test_tree_count_limit();
    set_tree_count(7'd127);
    classify();
    set_tree_count(7'd65);
    classify();
    set_tree_count(7'd64);
    classify();
  endtask

  task automatic test_ignored_requests();
    send_item(random_item(REQ_UNUSED));
    load_feature(3'd6, pick_value());
    load_feature(3'd7, pick_value());
    classify();
  endtask

  task automatic test_random_forests();
    int idle_pct [3] = '{0, 76, 6};
    int goal;
    int pick;
    for (int ph = 0; ph < 3; ph++) begin
      set_tree_count(pick_tree_count());
      sender_idle_pct = idle_pct[ph];
      goal = useful_items + 250;
      while (useful_items < goal) begin
        if ($urandom_range(0, 29) == 0)
          set_tree_count(pick_tree_count());
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          grow_tree(pick_tree());
        end else if (pick < 40) begin
          grow_chain(pick_tree());
        end else if (pick < 70) begin
          repeat ($urandom_range(0, 3)) load_feature(3'($urandom), pick_value());
          classify();
        end else if (pick < 80) begin
          load_feature(3'($urandom), pick_value());
        end else if (pick < 90) begin
          poke_node(pick_tree());
        end else if (pick < 95) begin
          send_item(random_item(REQ_UNUSED));
        end else begin
          classify();
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    init_stores();
    test_empty_forest();
    test_vote_rules();
    test_walk_limit();
    test_value_extremes();
    test_tree_count_limit();
    test_ignored_requests();
    test_random_forests();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
